FILE: design/rdcv_pkg.sv
// Shared types and constants for the ROI dominant color vote block.
package rdcv_pkg;

    localparam int CH_W      = 8;
    localparam int SUM_W     = CH_W + 1;
    localparam int NUM_LANES = 3;
    localparam int COUNT_W   = 23;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MIN_REG_W = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CH_W-1:0]  DIVISOR_RST = 8'd4;
    localparam logic [MIN_REG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [MIN_REG_W-1:0] HEIGHT_RST = 11'd480;

    // lane order in the shared divider
    localparam int LANE_BLUE  = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_RED   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOP_ROW      = 3'd0,
        REG_CENTER_COL   = 3'd1,
        REG_HALF_SIZE    = 3'd2,
        REG_DIVISOR      = 3'd3,
        REG_FRAME_WIDTH  = 3'd4,
        REG_FRAME_HEIGHT = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        COLOR_BLUE  = 2'd0,
        COLOR_RED   = 2'd1,
        COLOR_GREEN = 2'd2
    } color_t;

    typedef struct packed {
        logic busy;
    } div_stat_t;

    typedef logic [NUM_LANES-1:0][SUM_W-1:0] lane_vec_t;

endpackage

FILE: design/roi_dominant_color_vote.sv
// Top level: pixel sequencer, dominance counters and verdict output.
//
// Pixels arrive on the pix channel (col, row, red, green, blue, last_pixel);
// a request is taken when pix_valid is high and pix_stall is low. Each pixel
// passes through the shared divider (one quotient bit of the 9-bit channel
// sums per cycle), a state that sees it finish and a counter update, and the
// block returns to idle before the next one can be taken.
// Only a pixel with last_pixel set produces a result on the res channel
// (color, changed and the three totals); such a pixel also passes through
// an emit state before the next one is taken. The result sits in an output
// register; if res_stall holds it, the block keeps taking pixels and only
// waits when the next last pixel needs the register.
// Configuration registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; write them only while the block is idle.
// Reset clears the counters, the previous verdict and any pending result,
// and loads the register defaults (divisor 4, 640 by 480 frame).
module roi_dominant_color_vote
    import rdcv_pkg::*;
#(
    parameter int COORD_BITS = 11
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  logic [COORD_BITS-1:0] col,
    input  logic [COORD_BITS-1:0] row,
    input  logic [CH_W-1:0]       red,
    input  logic [CH_W-1:0]       green,
    input  logic [CH_W-1:0]       blue,
    input  logic                  last_pixel,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [1:0]            color,
    output logic                  changed,
    output logic [COUNT_W-1:0]    blue_total,
    output logic [COUNT_W-1:0]    red_total,
    output logic [COUNT_W-1:0]    green_total
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIVIDE = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic            in_roi;
    logic [CH_W-1:0] divisor_eff;
    lane_vec_t       dividend, quotient;
    div_stat_t       div_stat;
    logic            accept;

    logic [CH_W-1:0] red_reg, green_reg, blue_reg;
    logic            last_reg, roi_reg;
    lane_vec_t       sum_held;
    logic [NUM_LANES-1:0] dom;

    logic [COUNT_W-1:0] blue_cnt_reg, blue_cnt_next;
    logic [COUNT_W-1:0] red_cnt_reg, red_cnt_next;
    logic [COUNT_W-1:0] green_cnt_reg, green_cnt_next;
    color_t last_color_reg, last_color_next;
    logic   have_color_reg, have_color_next;

    logic            res_valid_reg, res_valid_next;
    color_t          verdict;
    logic            verdict_changed;
    logic            slot_free;
    logic            load_res;

    rdcv_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .col         (col),
        .row         (row),
        .in_roi      (in_roi),
        .divisor_eff (divisor_eff)
    );

    assign dividend[LANE_BLUE]  = SUM_W'(green) + SUM_W'(red);
    assign dividend[LANE_GREEN] = SUM_W'(blue) + SUM_W'(red);
    assign dividend[LANE_RED]   = SUM_W'(blue) + SUM_W'(green);

    rdcv_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (dividend),
        .divisor  (divisor_eff),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign pix_stall = (state_reg != ST_IDLE);
    assign accept    = pix_valid && !pix_stall;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            last_reg  <= last_pixel;
            roi_reg   <= in_roi;
        end
    end

    assign sum_held[LANE_BLUE]  = SUM_W'(green_reg) + SUM_W'(red_reg);
    assign sum_held[LANE_GREEN] = SUM_W'(blue_reg) + SUM_W'(red_reg);
    assign sum_held[LANE_RED]   = SUM_W'(blue_reg) + SUM_W'(green_reg);

    // channel > s - s/d
    assign dom[LANE_BLUE]  = SUM_W'(blue_reg)  > (sum_held[LANE_BLUE]  - quotient[LANE_BLUE]);
    assign dom[LANE_GREEN] = SUM_W'(green_reg) > (sum_held[LANE_GREEN] - quotient[LANE_GREEN]);
    assign dom[LANE_RED]   = SUM_W'(red_reg)   > (sum_held[LANE_RED]   - quotient[LANE_RED]);

    always_comb
    begin
        if (blue_cnt_reg > green_cnt_reg)
        begin
            verdict = (blue_cnt_reg > red_cnt_reg) ? COLOR_BLUE : COLOR_RED;
        end
        else
        begin
            verdict = (green_cnt_reg > red_cnt_reg) ? COLOR_GREEN : COLOR_RED;
        end
        verdict_changed = !have_color_reg || (verdict != last_color_reg);
    end

    assign slot_free = !res_valid_reg || !res_stall;
    assign load_res  = (state_reg == ST_EMIT) && slot_free;

    always_comb
    begin
        state_next      = state_reg;
        blue_cnt_next   = blue_cnt_reg;
        red_cnt_next    = red_cnt_reg;
        green_cnt_next  = green_cnt_reg;
        last_color_next = last_color_reg;
        have_color_next = have_color_reg;
        res_valid_next  = res_valid_reg && res_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (!div_stat.busy)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (roi_reg)
                begin
                    if (dom[LANE_BLUE] && (blue_cnt_reg != COUNT_MAX))
                    begin
                        blue_cnt_next = blue_cnt_reg + COUNT_W'(1);
                    end
                    if (dom[LANE_GREEN] && (green_cnt_reg != COUNT_MAX))
                    begin
                        green_cnt_next = green_cnt_reg + COUNT_W'(1);
                    end
                    if (dom[LANE_RED] && (red_cnt_reg != COUNT_MAX))
                    begin
                        red_cnt_next = red_cnt_reg + COUNT_W'(1);
                    end
                end
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    res_valid_next  = 1'b1;
                    last_color_next = verdict;
                    have_color_next = 1'b1;
                    blue_cnt_next   = '0;
                    red_cnt_next    = '0;
                    green_cnt_next  = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            blue_cnt_reg   <= '0;
            red_cnt_reg    <= '0;
            green_cnt_reg  <= '0;
            last_color_reg <= COLOR_BLUE;
            have_color_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            blue_cnt_reg   <= blue_cnt_next;
            red_cnt_reg    <= red_cnt_next;
            green_cnt_reg  <= green_cnt_next;
            last_color_reg <= last_color_next;
            have_color_reg <= have_color_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            color       <= verdict;
            changed     <= verdict_changed;
            blue_total  <= blue_cnt_reg;
            red_total   <= red_cnt_reg;
            green_total <= green_cnt_reg;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

FILE: design/rdcv_cfg.sv
// Configuration registers and region-of-interest test.
module rdcv_cfg
    import rdcv_pkg::*;
#(
    parameter int COORD_BITS = 11
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [COORD_BITS-1:0] col,
    input  logic [COORD_BITS-1:0] row,
    output logic                  in_roi,
    output logic [CH_W-1:0]       divisor_eff
);

    localparam int REG_W = (COORD_BITS < MIN_REG_W) ? MIN_REG_W : COORD_BITS;
    localparam int EXT_W = REG_W + 3;

    logic [REG_W-1:0] top_row_reg, center_col_reg, half_size_reg;
    logic [REG_W-1:0] frame_width_reg, frame_height_reg;
    logic [CH_W-1:0]  divisor_reg;
    logic [REG_W-1:0] coord_wdata;

    logic [EXT_W-1:0] twice_c, three_r, lo, hi_raw, hi, top, fh, fw, col_x, row_x;

    assign cfg_ready   = 1'b1;
    assign coord_wdata = REG_W'(cfg_data[COORD_BITS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_row_reg      <= '0;
            center_col_reg   <= '0;
            half_size_reg    <= '0;
            divisor_reg      <= DIVISOR_RST;
            frame_width_reg  <= REG_W'(WIDTH_RST);
            frame_height_reg <= REG_W'(HEIGHT_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TOP_ROW:      top_row_reg      <= coord_wdata;
                REG_CENTER_COL:   center_col_reg   <= coord_wdata;
                REG_HALF_SIZE:    half_size_reg    <= coord_wdata;
                REG_DIVISOR:      divisor_reg      <= cfg_data[CH_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= coord_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= coord_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        twice_c = EXT_W'(center_col_reg) << 1;
        three_r = (EXT_W'(half_size_reg) << 1) + EXT_W'(half_size_reg);
        lo      = (twice_c > three_r) ? ((twice_c - three_r) >> 1) : '0;
        hi_raw  = (twice_c + three_r) >> 1;
        fw      = EXT_W'(frame_width_reg);
        fh      = EXT_W'(frame_height_reg);
        hi      = (hi_raw > fw) ? fw : hi_raw;
        top     = (EXT_W'(top_row_reg) > fh) ? '0 : EXT_W'(top_row_reg);
        col_x   = EXT_W'(col);
        row_x   = EXT_W'(row);
        in_roi  = (row_x >= top) && (row_x < fh) && (col_x >= lo) && (col_x < hi);
    end

    assign divisor_eff = (divisor_reg == '0) ? CH_W'(1) : divisor_reg;

endmodule

FILE: design/rdcv_divider.sv
// Shared restoring divider, one quotient bit per cycle for all three sums.
module rdcv_divider
    import rdcv_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  lane_vec_t       dividend,
    input  logic [CH_W-1:0] divisor,
    output lane_vec_t       quotient,
    output div_stat_t       stat
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [CH_W-1:0]  dsr_reg, dsr_next;
    logic [NUM_LANES-1:0][CH_W-1:0] rem_reg, rem_next;
    lane_vec_t        quo_reg, quo_next;
    logic [SUM_W-1:0] shifted;
    logic             qbit;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        shifted   = '0;
        qbit      = 1'b0;
        if (start)
        begin
            cnt_next  = CNT_W'(SUM_W);
            busy_next = 1'b1;
            dsr_next  = divisor;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                shifted = {rem_reg[i], quo_reg[i][SUM_W-1]};
                qbit    = (shifted >= {1'b0, dsr_reg});
                rem_next[i] = qbit ? CH_W'(shifted - {1'b0, dsr_reg}) : shifted[CH_W-1:0];
                quo_next[i] = {quo_reg[i][SUM_W-2:0], qbit};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;

endmodule
